### hdl/dtdg_pkg.sv
// Shared types, constants and tables of the dual-tone DDS generator
package dtdg_pkg;

  localparam int STEP_W       = 15;
  localparam int PHASE_W      = 16;
  localparam int SAMPLE_W     = 7;
  localparam int LEVEL_W      = 8;
  localparam int KEY_W        = 4;
  localparam int NUM_STEPS    = 8;
  localparam int CFG_IDX_W    = 4;
  localparam int WAVE_POINTS  = 128;
  localparam int SINE_ENTRIES = 128;

  // request codes; code three changes no state but still yields a zero-level result
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2
  } req_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key_index;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pwm_level;
    logic               tone_active;
  } out_item_t;

  // per-channel accumulator control
  typedef struct packed {
    logic load;
    logic advance;
  } tone_ctrl_t;

  // reset tuning words: four low-group, then four high-group
  localparam logic [STEP_W-1:0] STEP_RESET [NUM_STEPS] = '{
    15'd365, 15'd404, 15'd447, 15'd493, 15'd634, 15'd700, 15'd774, 15'd856
  };

  // one period of the base sine, 128 points, 7 bits
  localparam logic [SAMPLE_W-1:0] WAVE [WAVE_POINTS] = '{
    7'd64,  7'd67,  7'd70,  7'd73,  7'd76,  7'd79,  7'd82,  7'd85,
    7'd88,  7'd91,  7'd94,  7'd96,  7'd99,  7'd102, 7'd104, 7'd106,
    7'd109, 7'd111, 7'd113, 7'd115, 7'd117, 7'd118, 7'd120, 7'd121,
    7'd123, 7'd124, 7'd125, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
    7'd127, 7'd127, 7'd127, 7'd127, 7'd126, 7'd126, 7'd125, 7'd124,
    7'd123, 7'd121, 7'd120, 7'd118, 7'd117, 7'd115, 7'd113, 7'd111,
    7'd109, 7'd106, 7'd104, 7'd102, 7'd99,  7'd96,  7'd94,  7'd91,
    7'd88,  7'd85,  7'd82,  7'd79,  7'd76,  7'd73,  7'd70,  7'd67,
    7'd64,  7'd60,  7'd57,  7'd54,  7'd51,  7'd48,  7'd45,  7'd42,
    7'd39,  7'd36,  7'd33,  7'd31,  7'd28,  7'd25,  7'd23,  7'd21,
    7'd18,  7'd16,  7'd14,  7'd12,  7'd10,  7'd9,   7'd7,   7'd6,
    7'd4,   7'd3,   7'd2,   7'd1,   7'd1,   7'd0,   7'd0,   7'd0,
    7'd0,   7'd0,   7'd0,   7'd0,   7'd1,   7'd1,   7'd2,   7'd3,
    7'd4,   7'd6,   7'd7,   7'd9,   7'd10,  7'd12,  7'd14,  7'd16,
    7'd18,  7'd21,  7'd23,  7'd25,  7'd28,  7'd31,  7'd33,  7'd36,
    7'd39,  7'd42,  7'd45,  7'd48,  7'd51,  7'd54,  7'd57,  7'd60
  };

endpackage

### hdl/dtdg_step_regs.sv
// Tuning word register file, written through a plain write port
module dtdg_step_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dtdg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dtdg_pkg::STEP_W-1:0]         cfg_data_i,
  output logic [dtdg_pkg::STEP_W-1:0]         steps_o [dtdg_pkg::NUM_STEPS]
);

  logic [dtdg_pkg::STEP_W-1:0] steps_q [dtdg_pkg::NUM_STEPS];

  // writes beyond the register list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dtdg_pkg::NUM_STEPS; i++) begin
        steps_q[i] <= dtdg_pkg::STEP_RESET[i];
      end
    end else begin
      for (int i = 0; i < dtdg_pkg::NUM_STEPS; i++) begin
        if (cfg_we_i && (cfg_idx_i == dtdg_pkg::CFG_IDX_W'(i))) begin
          steps_q[i] <= cfg_data_i;
        end
      end
    end
  end

  assign steps_o = steps_q;

endmodule

### hdl/dtdg_tone.sv
// One tone channel: selected tuning word, phase accumulator, sine lookup
module dtdg_tone #(
  parameter int SINE_ENTRIES = dtdg_pkg::SINE_ENTRIES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dtdg_pkg::tone_ctrl_t           ctrl_i,
  input  logic [dtdg_pkg::STEP_W-1:0]    step_i,
  output logic [dtdg_pkg::SAMPLE_W-1:0]  sample_o
);

  localparam int IDX_W  = $clog2(SINE_ENTRIES);
  localparam int DEPTH  = 2 ** IDX_W;
  localparam int PROD_W = dtdg_pkg::STEP_W + IDX_W + 1;
  localparam logic [IDX_W:0] MULT = (IDX_W + 1)'(SINE_ENTRIES);

  logic [dtdg_pkg::PHASE_W-1:0]  phase_q, phase_d;
  logic [dtdg_pkg::STEP_W-1:0]   step_q;
  logic [PROD_W-1:0]             prod;
  logic [IDX_W-1:0]              idx;
  logic [dtdg_pkg::SAMPLE_W-1:0] sine_tab [DEPTH];

  // resampled sine table, built at elaboration; unused tail reads zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_tab
    if (i < SINE_ENTRIES) begin : g_used
      assign sine_tab[i] =
        dtdg_pkg::WAVE[(i * dtdg_pkg::WAVE_POINTS / SINE_ENTRIES) % dtdg_pkg::WAVE_POINTS];
    end else begin : g_pad
      assign sine_tab[i] = '0;
    end
  end

  // next phase, wraps at 16 bits
  assign phase_d = phase_q + {1'b0, step_q};

  // table index from phase bits 14:0 scaled to SINE_ENTRIES
  assign prod     = PROD_W'(phase_d[dtdg_pkg::STEP_W-1:0]) * PROD_W'(MULT);
  assign idx      = prod[dtdg_pkg::STEP_W +: IDX_W];
  assign sample_o = sine_tab[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
    end else begin
      if (ctrl_i.advance) begin
        phase_q <= phase_d;
      end
      if (ctrl_i.load) begin
        step_q <= step_i;
      end
    end
  end

endmodule

### hdl/dual_tone_dds_generator_core.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_data_i  (req_type, key_index)
// out       output     out_valid_o / out_ready_i out_data_o (pwm_level, tone_active)
// cfg       input      cfg_we_i, no wait         cfg_idx_i, cfg_data_i
//
// One request per cycle unless the output stalls; its result appears in the
// output register in the cycle after the transfer. Accumulator add, table index
// scaling and sine lookup sit between the phase registers and output register.
// Reset clears phases, selected words and the tone state; tuning words return
// to their defaults. A stalled output is held, and a new request is still taken
// in the cycle the held result is transferred.
module dual_tone_dds_generator_core #(
  parameter int SINE_ENTRIES = dtdg_pkg::SINE_ENTRIES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  dtdg_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output dtdg_pkg::out_item_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [dtdg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dtdg_pkg::STEP_W-1:0]       cfg_data_i
);

  logic [dtdg_pkg::STEP_W-1:0]   steps [dtdg_pkg::NUM_STEPS];
  logic [dtdg_pkg::STEP_W-1:0]   low_step, high_step;
  logic [dtdg_pkg::SAMPLE_W-1:0] low_sample, high_sample;
  dtdg_pkg::tone_ctrl_t          tone_ctrl;
  dtdg_pkg::out_item_t           out_data_q, out_data_d;
  logic                          out_valid_q;
  logic                          sounding_q, sounding_d;
  logic                          in_fire;
  logic [dtdg_pkg::LEVEL_W-1:0]  level;

  dtdg_step_regs u_step_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .steps_o    (steps)
  );

  // word selection from the key: row picks low group, column high group
  assign low_step  = steps[{1'b0, in_data_i.key_index[3:2]}];
  assign high_step = steps[{1'b1, in_data_i.key_index[1:0]}];

  dtdg_tone #(.SINE_ENTRIES(SINE_ENTRIES)) u_low_tone (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (tone_ctrl),
    .step_i   (low_step),
    .sample_o (low_sample)
  );

  dtdg_tone #(.SINE_ENTRIES(SINE_ENTRIES)) u_high_tone (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (tone_ctrl),
    .step_i   (high_step),
    .sample_o (high_sample)
  );

  // take a request whenever the output register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // mix: high + low - low/4, never exceeds 8 bits
  assign level = dtdg_pkg::LEVEL_W'(high_sample) + dtdg_pkg::LEVEL_W'(low_sample)
               - dtdg_pkg::LEVEL_W'(low_sample >> 2);

  // request decode
  always_comb begin
    tone_ctrl            = '0;
    sounding_d           = sounding_q;
    out_data_d.pwm_level = '0;
    case (in_data_i.req_type)
      dtdg_pkg::REQ_TICK: begin
        tone_ctrl.advance = in_fire && sounding_q;
        if (sounding_q) begin
          out_data_d.pwm_level = level;
        end
      end
      dtdg_pkg::REQ_START: begin
        tone_ctrl.load = in_fire;
        sounding_d     = 1'b1;
      end
      dtdg_pkg::REQ_STOP: begin
        sounding_d = 1'b0;
      end
      default: begin
        sounding_d = sounding_q;
      end
    endcase
    out_data_d.tone_active = sounding_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sounding_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        sounding_q <= sounding_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // every accepted request leaves a result behind
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted request produced no result");

  // stop silences at once
  a_stop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.req_type == dtdg_pkg::REQ_STOP)
    |=> !out_data_q.tone_active && (out_data_q.pwm_level == '0))
    else $error("stop did not silence the output");

  // start turns the tone on with a zero level in that result
  a_start_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.req_type == dtdg_pkg::REQ_START)
    |=> out_data_q.tone_active && (out_data_q.pwm_level == '0))
    else $error("start result wrong");

  // a nonzero level only while sounding
  a_level_needs_tone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q.pwm_level != '0) |-> out_data_q.tone_active)
    else $error("level present while silent");

  // phases only move on a tick while sounding
  a_advance_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tone_ctrl.advance |-> sounding_q && in_fire
      && (in_data_i.req_type == dtdg_pkg::REQ_TICK))
    else $error("phase advanced outside a sounding tick");

endmodule
